/* rtl/rslr_pkg.sv */
// ----------------------------------------------------------------------------
// rslr_pkg
// Types and constants shared by the run-slice line rasterizer.
// ----------------------------------------------------------------------------
package rslr_pkg;

	localparam int COORD_BITS = 11;
	localparam int COLOR_BITS = 32;

	typedef logic [COORD_BITS-1:0] coord_t;

	// what the current line is drawn as
	typedef enum logic [2:0] {
		KIND_IDLE  = 3'd0,
		KIND_POINT = 3'd1,
		KIND_VERT  = 3'd2,
		KIND_HORZ  = 3'd3,
		KIND_DIAG  = 3'd4,
		KIND_XMAJ  = 3'd5,
		KIND_YMAJ  = 3'd6
	} line_kind_t;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic                  func;
		coord_t                start_x;
		coord_t                start_y;
		coord_t                end_x;
		coord_t                end_y;
		logic [COLOR_BITS-1:0] color;
	} cmd_word_t;

	typedef struct packed {
		coord_t                pixel_x;
		coord_t                pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  last_pixel;
	} pix_word_t;

endpackage

/* rtl/rslr_div.sv */
// ----------------------------------------------------------------------------
// rslr_div
// Restoring divider, one quotient bit per cycle, shared by the line setup.
// ----------------------------------------------------------------------------
module rslr_div #(
	parameter int W = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  div_q;
	logic [W:0]    trial;
	logic          fits;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low W bits carry it
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/run_slice_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// run_slice_line_rasterizer
// Line rasterizer: a load word sets up a line, each tick word emits its next pixel while a line is active.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | word
// cmd     | in  | cmd_valid/cmd_ready  | cmd_word_t (func, endpoints, color)
// pix     | out | pix_valid/pix_ready  | pix_word_t (x, y, color, last)
//
// Ticks stream at one word per cycle while the pix side is not stalled.
// A load of a point, vertical, horizontal or diagonal line needs no divider.
// A load of an x- or y-major line runs the shared divider once or twice,
// with cmd_ready low until the divider is through.
// A pixel waits in the output register; a stalled pix side holds off cmd.
// Reset leaves no line active; ticks before the first load are dropped.
// ----------------------------------------------------------------------------
module run_slice_line_rasterizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  rslr_pkg::cmd_word_t cmd,
	output logic               pix_valid,
	input  logic               pix_ready,
	output rslr_pkg::pix_word_t pix
);
	import rslr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE       = 3'b001,
		ST_DIV_RUN    = 3'b010,
		ST_DIV_SPREAD = 3'b100
	} seq_state_t;

	seq_state_t            state_q, state_d;
	line_kind_t            kind_q, kind_d;
	coord_t                cur_x_q, cur_x_d;
	coord_t                cur_y_q, cur_y_d;
	coord_t                tgt_x_q, tgt_x_d;
	coord_t                tgt_y_q, tgt_y_d;
	logic [COLOR_BITS-1:0] color_q, color_d;
	logic                  down_q, down_d;
	coord_t                run_len_q, run_len_d;
	coord_t                spare_q, spare_d;
	coord_t                period_q, period_d;
	coord_t                phase_q, phase_d;
	coord_t                rmod_q, rmod_d;   // slice index modulo the period
	logic                  extra_q, extra_d;
	coord_t                dy_q, dy_d;

	logic                  pix_valid_q;
	pix_word_t             pix_q;

	logic                  cmd_acc;
	logic                  emit;
	logic                  last;

	// load decode
	coord_t                sx, sy, ex, ey, dx, dy, major, minor;
	logic                  ld_down;
	line_kind_t            ld_kind;

	// divider
	logic                  div_start;
	coord_t                div_dividend, div_divisor;
	logic                  div_done;
	coord_t                div_quo, div_rem;

	// slice stepping
	coord_t                ph_inc, rmod_inc;
	logic                  slice_end;

	assign cmd_ready = (state_q == ST_IDLE) && (!pix_valid_q || pix_ready);
	assign cmd_acc   = cmd_valid && cmd_ready;

	function automatic coord_t y_step(input coord_t y, input logic dn);
		return dn ? y - COORD_BITS'(1) : y + COORD_BITS'(1);
	endfunction

	always_comb begin
		if (cmd.end_x < cmd.start_x) begin
			sx = cmd.end_x;
			sy = cmd.end_y;
			ex = cmd.start_x;
			ey = cmd.start_y;
		end else begin
			sx = cmd.start_x;
			sy = cmd.start_y;
			ex = cmd.end_x;
			ey = cmd.end_y;
		end
		dx      = ex - sx;
		ld_down = (ey < sy);
		dy      = ld_down ? sy - ey : ey - sy;
		if (dx > dy) begin
			major = dx;
			minor = dy;
		end else begin
			major = dy;
			minor = dx;
		end
		priority if (dx == '0 && dy == '0) ld_kind = KIND_POINT;
		else if (dx == '0)                 ld_kind = KIND_VERT;
		else if (dy == '0)                 ld_kind = KIND_HORZ;
		else if (dx == dy)                 ld_kind = KIND_DIAG;
		else if (dx > dy)                  ld_kind = KIND_XMAJ;
		else                               ld_kind = KIND_YMAJ;
	end

	rslr_div #(
		.W(COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign ph_inc   = phase_q + COORD_BITS'(1);
	assign rmod_inc = rmod_q + COORD_BITS'(1);

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		tgt_x_d   = tgt_x_q;
		tgt_y_d   = tgt_y_q;
		color_d   = color_q;
		down_d    = down_q;
		run_len_d = run_len_q;
		spare_d   = spare_q;
		period_d  = period_q;
		phase_d   = phase_q;
		rmod_d    = rmod_q;
		extra_d   = extra_q;
		dy_d      = dy_q;
		emit      = 1'b0;
		last      = 1'b0;
		slice_end = 1'b0;
		div_start    = 1'b0;
		div_dividend = major;
		div_divisor  = minor + COORD_BITS'(1);

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && cmd.func == FUNC_LOAD) begin
					cur_x_d   = sx;
					cur_y_d   = sy;
					tgt_x_d   = ex;
					tgt_y_d   = ey;
					color_d   = cmd.color;
					down_d    = ld_down;
					kind_d    = ld_kind;
					dy_d      = dy;
					run_len_d = '0;
					spare_d   = '0;
					period_d  = COORD_BITS'(1);
					phase_d   = '0;
					rmod_d    = '0;
					extra_d   = 1'b0;
					if (ld_kind == KIND_XMAJ || ld_kind == KIND_YMAJ) begin
						div_start = 1'b1;
						state_d   = ST_DIV_RUN;
					end
				end else if (cmd_acc && kind_q != KIND_IDLE) begin
					emit = 1'b1;
					unique case (kind_q)
						KIND_POINT: last = 1'b1;
						KIND_VERT: begin
							if (cur_y_q == tgt_y_q) last = 1'b1;
							else cur_y_d = y_step(cur_y_q, down_q);
						end
						KIND_HORZ: begin
							if (cur_x_q == tgt_x_q) last = 1'b1;
							else cur_x_d = cur_x_q + COORD_BITS'(1);
						end
						KIND_DIAG: begin
							if (cur_x_q == tgt_x_q) last = 1'b1;
							else begin
								cur_x_d = cur_x_q + COORD_BITS'(1);
								cur_y_d = y_step(cur_y_q, down_q);
							end
						end
						KIND_XMAJ, KIND_YMAJ: begin
							// step along the major axis
							if (kind_q == KIND_XMAJ) cur_x_d = cur_x_q + COORD_BITS'(1);
							else cur_y_d = y_step(cur_y_q, down_q);
							if (extra_q) begin
								extra_d = 1'b0;
								if (spare_q != '0) spare_d = spare_q - COORD_BITS'(1);
								slice_end = 1'b1;
							end else begin
								phase_d = ph_inc;
								if (ph_inc >= run_len_q) begin
									if (spare_q != '0 && rmod_q == '0) extra_d = 1'b1;
									else slice_end = 1'b1;
								end
							end
							if (slice_end) begin
								phase_d = '0;
								// minor-axis step, or done if already at the end
								if (kind_q == KIND_XMAJ) begin
									if (cur_y_q == tgt_y_q) last = 1'b1;
									else cur_y_d = y_step(cur_y_q, down_q);
								end else begin
									if (cur_x_q == tgt_x_q) last = 1'b1;
									else cur_x_d = cur_x_q + COORD_BITS'(1);
								end
								if (!last) rmod_d = (rmod_inc == period_q) ? '0 : rmod_inc;
							end
						end
						default: last = 1'b0;
					endcase
					if (last) kind_d = KIND_IDLE;
				end
			end
			ST_DIV_RUN: begin
				div_dividend = dy_q;
				div_divisor  = div_rem;
				if (div_done) begin
					run_len_d = div_quo;
					spare_d   = div_rem;
					if (div_rem != '0) begin
						div_start = 1'b1;
						state_d   = ST_DIV_SPREAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIV_SPREAD: begin
				if (div_done) begin
					period_d = (div_quo == '0) ? COORD_BITS'(1) : div_quo;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			color_q     <= '0;
			down_q      <= 1'b0;
			run_len_q   <= '0;
			spare_q     <= '0;
			period_q    <= COORD_BITS'(1);
			phase_q     <= '0;
			rmod_q      <= '0;
			extra_q     <= 1'b0;
			dy_q        <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			kind_q    <= kind_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			tgt_x_q   <= tgt_x_d;
			tgt_y_q   <= tgt_y_d;
			color_q   <= color_d;
			down_q    <= down_d;
			run_len_q <= run_len_d;
			spare_q   <= spare_d;
			period_q  <= period_d;
			phase_q   <= phase_d;
			rmod_q    <= rmod_d;
			extra_q   <= extra_d;
			dy_q      <= dy_d;
			if (emit) pix_valid_q <= 1'b1;
			else if (pix_ready) pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q.pixel_x     <= cur_x_q;
			pix_q.pixel_y     <= cur_y_q;
			pix_q.pixel_color <= color_q;
			pix_q.last_pixel  <= last;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

/* rtl/rslr_checker.sv */
// ----------------------------------------------------------------------------
// rslr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module rslr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input rslr_pkg::cmd_word_t cmd,
	input logic               pix_valid,
	input logic               pix_ready,
	input rslr_pkg::pix_word_t pix
);
	import rslr_pkg::*;

	// a held pixel stays put until taken
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel changed or dropped while stalled");

	// no command is taken while a pixel is stuck in the output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && pix_valid && !pix_ready))
		else $error("command accepted over a stalled pixel");

	// a load never produces a pixel
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.func == FUNC_LOAD && !pix_valid |=> !pix_valid)
		else $error("pixel after a load word");

	// the last pixel of a line is never followed at once by another pixel
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.last_pixel |=> !pix_valid)
		else $error("pixel right after the last pixel");

endmodule

bind run_slice_line_rasterizer rslr_checker u_rslr_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the run-slice line rasterizer. Load words set up lines and
// tick words pull pixels out. A line tracer in the bench follows the block
// word by word. Each emitted pixel is checked in order against what the
// tracer predicts. Directed lines of every class come first, then random
// short lines and noise under random idling on both sides, and last a few
// longer lines near the edges streamed without idling.
// ----------------------------------------------------------------------------
module tb;
	import rslr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      pix_valid;
	logic      pix_ready = 1'b1;
	pix_word_t pix;

	run_slice_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always #6 clk = ~clk;

	pix_word_t  pixels_due[$];
	pix_word_t  pixel_want;
	int         mismatches = 0;
	int         live_words = 0;
	int         cycle_count = 0;
	bit         idling_on = 1'b1;

	// line tracer state, reset values
	coord_t      cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
	coord_t      run_len = '0, spare = '0, period = coord_t'(1);
	coord_t      run_idx = '0, phase = '0;
	logic [31:0] pen = '0;
	bit          going_down = 1'b0, extra = 1'b0;
	line_kind_t  kind = KIND_IDLE;

	function automatic coord_t y_step(coord_t y);
		return going_down ? y - 1'b1 : y + 1'b1;
	endfunction

	function automatic void load_line(cmd_word_t w);
		coord_t sx, sy, ex, ey, dx, dy, major, minor, rem;
		sx = w.start_x; sy = w.start_y; ex = w.end_x; ey = w.end_y;
		if (ex < sx) begin
			sx = w.end_x; sy = w.end_y; ex = w.start_x; ey = w.start_y;
		end
		dx = ex - sx;
		going_down = (ey < sy);
		dy = going_down ? sy - ey : ey - sy;
		cur_x = sx; cur_y = sy; tgt_x = ex; tgt_y = ey;
		pen = w.color;
		run_idx = '0; phase = '0; extra = 1'b0;
		run_len = '0; spare = '0; period = coord_t'(1);
		if (dx == 0 && dy == 0)
			kind = KIND_POINT;
		else if (dx == 0)
			kind = KIND_VERT;
		else if (dy == 0)
			kind = KIND_HORZ;
		else if (dx == dy)
			kind = KIND_DIAG;
		else begin
			if (dx > dy) begin
				kind = KIND_XMAJ; major = dx; minor = dy;
			end else begin
				kind = KIND_YMAJ; major = dy; minor = dx;
			end
			run_len = major / (minor + 1'b1);
			rem = major % (minor + 1'b1);
			spare = rem;
			// spread period is dy-based for both major classes
			period = (rem != 0) ? dy / rem : coord_t'(1);
			if (period == 0)
				period = coord_t'(1);
		end
	endfunction

	// one pixel step of an x- or y-major line; returns 1 on the final pixel
	function automatic bit slice_step();
		bit xm, slice_end;
		xm = (kind == KIND_XMAJ);
		slice_end = 1'b0;
		if (xm)
			cur_x = cur_x + 1'b1;
		else
			cur_y = y_step(cur_y);
		if (extra) begin
			extra = 1'b0;
			if (spare != 0)
				spare = spare - 1'b1;
			slice_end = 1'b1;
		end else begin
			phase = phase + 1'b1;
			if (phase >= run_len) begin
				if (spare != 0 && period != 0 && run_idx % period == 0)
					extra = 1'b1;
				else
					slice_end = 1'b1;
			end
		end
		if (!slice_end)
			return 1'b0;
		phase = '0;
		if (xm) begin
			if (cur_y == tgt_y)
				return 1'b1;
			cur_y = y_step(cur_y);
		end else begin
			if (cur_x == tgt_x)
				return 1'b1;
			cur_x = cur_x + 1'b1;
		end
		run_idx = run_idx + 1'b1;
		return 1'b0;
	endfunction

	function automatic void trace_word(cmd_word_t w, output bit emits, output pix_word_t px);
		bit last;
		emits = 1'b0;
		px = '0;
		last = 1'b0;
		if (w.func == FUNC_LOAD)
			load_line(w);
		else if (kind != KIND_IDLE) begin
			emits = 1'b1;
			px.pixel_x = cur_x;
			px.pixel_y = cur_y;
			px.pixel_color = pen;
			case (kind)
				KIND_POINT: last = 1'b1;
				KIND_VERT: begin
					if (cur_y == tgt_y)
						last = 1'b1;
					else
						cur_y = y_step(cur_y);
				end
				KIND_HORZ: begin
					if (cur_x == tgt_x)
						last = 1'b1;
					else
						cur_x = cur_x + 1'b1;
				end
				KIND_DIAG: begin
					if (cur_x == tgt_x)
						last = 1'b1;
					else begin
						cur_x = cur_x + 1'b1;
						cur_y = y_step(cur_y);
					end
				end
				default: last = slice_step();
			endcase
			if (last)
				kind = KIND_IDLE;
			px.last_pixel = last;
		end
	endfunction

	function automatic cmd_word_t random_word();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(cmd_word_t)-1:0];
	endfunction

	function automatic cmd_word_t tick_word();
		cmd_word_t w;
		w = random_word();
		w.func = FUNC_TICK;
		return w;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(COORD_MAX - 15, COORD_MAX);
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	function automatic int aim(int from, int span);
		int to;
		to = $urandom_range(0, 1) ? from + span : from - span;
		if (to > COORD_MAX)
			to = from - span;
		if (to < 0)
			to = from + span;
		if (to > COORD_MAX)
			to = COORD_MAX;
		return to;
	endfunction

	// sends one word; valid is left high so a following word can go back to back
	task automatic send_word(input cmd_word_t w, output bit last);
		int gap;
		bit emits;
		pix_word_t px;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (!cmd_ready);
		trace_word(w, emits, px);
		if (emits)
			pixels_due.push_back(px);
		if (emits || w.func == FUNC_LOAD)
			live_words++;
		last = emits && px.last_pixel;
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0);
	endtask

	// load a line, then tick until its last pixel or until cut ticks are sent
	task automatic draw_line(input int sx, sy, ex, ey, input logic [31:0] color,
			input int cut);
		cmd_word_t w;
		bit last;
		int n;
		w = random_word();
		w.func = FUNC_LOAD;
		w.start_x = coord_t'(sx);
		w.start_y = coord_t'(sy);
		w.end_x = coord_t'(ex);
		w.end_y = coord_t'(ey);
		w.color = color;
		send_word(w, last);
		last = 1'b0;
		n = 0;
		while (!last && (cut == 0 || n < cut) && n < 5000) begin
			send_word(tick_word(), last);
			n++;
		end
	endtask

	task automatic test_idle_tick();
		bit last;
		send_word(tick_word(), last);
	endtask

	task automatic test_point();
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 0);
	endtask

	task automatic test_vertical();
		draw_line(0, COORD_MAX, 0, COORD_MAX - 1, 32'h0000_0000, 0);
	endtask

	task automatic test_reversed_horizontal();
		draw_line(COORD_MAX, 5, COORD_MAX - 2, 5, 32'hA5A5_5A5A, 0);
	endtask

	task automatic test_diagonal_down();
		draw_line(0, 2, 2, 0, 32'h1234_5678, 0);
	endtask

	task automatic test_x_major();
		draw_line(0, 0, 4, 1, 32'h8000_0001, 0);
	endtask

	// y-major line dropped after two pixels by a new load
	task automatic test_reload_mid_line();
		draw_line(7, 0, 8, 6, 32'h0F0F_F0F0, 2);
		draw_line(1, 1, 1, 1, 32'hFFFF_FFFF, 0);
	endtask

	task automatic draw_random_line();
		int sx, sy, dx, dy, cut;
		bit last;
		sx = pick_coord();
		sy = pick_coord();
		dx = $urandom_range(0, 24);
		dy = $urandom_range(0, 24);
		case ($urandom_range(0, 9))
			0: begin
				dx = 0; dy = 0;
			end
			1: dx = 0;
			2: dy = 0;
			3: dy = dx;
			4: begin
				dx = $urandom_range(0, 300);
				dy = $urandom_range(0, 300);
			end
			default: ;
		endcase
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
		draw_line(sx, sy, aim(sx, dx), aim(sy, dy), $urandom(), cut);
		// extra ticks land on an idle block or on the rest of a cut line
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) send_word(tick_word(), last);
	endtask

	task automatic test_random_lines();
		int goal;
		bit last, paused;
		goal = live_words + 640;
		paused = 1'b0;
		while (live_words < goal) begin
			if ($urandom_range(0, 9) == 0)
				send_word(random_word(), last);
			else
				draw_random_line();
			if (!paused && live_words >= goal - 400) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_long_lines();
		idling_on = 1'b0;
		draw_line(COORD_MAX - 60, 0, COORD_MAX, 23, $urandom(), 0);
		draw_line(600, COORD_MAX, 590, COORD_MAX - 47, $urandom(), 0);
		draw_line(0, 40, 13, 0, $urandom(), 0);
		draw_line(COORD_MAX, 1024, COORD_MAX - 30, 1024, $urandom(), 0);
	endtask

	// output side stalls in bursts while idling is on
	initial begin
		wait (arst_n);
		forever begin
			if (idling_on && $urandom_range(0, 2) == 0) begin
				pix_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			pix_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel: x=%0d y=%0d color=%h last=%0d",
						pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
			end else begin
				pixel_want = pixels_due.pop_front();
				if (pix.pixel_x !== pixel_want.pixel_x || pix.pixel_y !== pixel_want.pixel_y
						|| pix.pixel_color !== pixel_want.pixel_color
						|| pix.last_pixel !== pixel_want.last_pixel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: expected x=%0d y=%0d color=%h last=%0d, got x=%0d y=%0d color=%h last=%0d",
							pixel_want.pixel_x, pixel_want.pixel_y, pixel_want.pixel_color,
							pixel_want.last_pixel, pix.pixel_x, pix.pixel_y,
							pix.pixel_color, pix.last_pixel);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_idle_tick();
		test_point();
		test_vertical();
		test_reversed_horizontal();
		test_diagonal_down();
		test_x_major();
		test_reload_mid_line();
		test_random_lines();
		test_long_lines();
		drain();
		repeat (40) @(posedge clk);
		mismatches += pixels_due.size();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* run_slice_line_rasterizer.f */
rtl/rslr_pkg.sv
rtl/rslr_div.sv
rtl/run_slice_line_rasterizer.sv
rtl/rslr_checker.sv
bench/tb.sv
